>>> design/fbm_pkg.sv
// Shared types and constants for the fBm gradient noise block.
package fbm_pkg;

  localparam int COORD_BITS = 12;
  localparam int FREQ_W     = 24;
  localparam int OCT_W      = 4;
  localparam int HEIGHT_W   = 17;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = '1;

  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 21;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef enum logic [1:0] {
    OP_LOAD_PERM = 2'd0,
    OP_LOAD_GRAD = 2'd1,
    OP_SAMPLE    = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    REG_OCTAVE_COUNT = 1'b0,
    REG_BASE_FREQ    = 1'b1
  } reg_idx_t;

  typedef struct packed {
    op_t                    op;
    logic [7:0]             table_index;
    logic [7:0]             perm_value;
    logic signed [15:0]     grad_x;
    logic signed [15:0]     grad_y;
    logic [COORD_BITS-1:0]  coord_x;
    logic [COORD_BITS-1:0]  coord_z;
  } fbm_item_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic [HEIGHT_W-1:0] min_height;
    logic [HEIGHT_W-1:0] max_height;
  } fbm_result_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SCL_X,
    S_SCL_Z,
    S_SCL_W,
    S_F_SQ,
    S_F_CUBE,
    S_F_POLY,
    S_F_DONE,
    S_H_P1,
    S_H_P2,
    S_H_G,
    S_D_X,
    S_D_Y,
    S_D_S,
    S_L_A,
    S_L_B,
    S_L_C,
    S_L_D,
    S_L_E,
    S_FIN
  } state_t;

endpackage

>>> design/fbm_mul.sv
// Shared signed multiplier with registered product.
module fbm_mul (
  input  logic                                clk,
  input  logic signed [fbm_pkg::MUL_A_W-1:0]  a,
  input  logic signed [fbm_pkg::MUL_B_W-1:0]  b,
  output logic signed [fbm_pkg::MUL_P_W-1:0]  p
);
  import fbm_pkg::*;

  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

>>> design/fbm_tables.sv
// Permutation and gradient table memories, one write and one registered read each.
module fbm_tables #(
  parameter int TABLE_SIZE = 256
) (
  input  logic                          clk,
  input  logic                          perm_we,
  input  logic                          grad_we,
  input  logic [$clog2(TABLE_SIZE)-1:0] waddr,
  input  logic [7:0]                    perm_wdata,
  input  logic [31:0]                   grad_wdata,
  input  logic                          perm_re,
  input  logic [$clog2(TABLE_SIZE)-1:0] perm_raddr,
  input  logic                          grad_re,
  input  logic [$clog2(TABLE_SIZE)-1:0] grad_raddr,
  output logic [7:0]                    perm_rdata,
  output logic [31:0]                   grad_rdata
);

  logic [7:0]  perm_mem [TABLE_SIZE];
  logic [31:0] grad_mem [TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (perm_we) begin
      perm_mem[waddr] <= perm_wdata;
    end
    if (perm_re) begin
      perm_rdata <= perm_mem[perm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (grad_we) begin
      grad_mem[waddr] <= grad_wdata;
    end
    if (grad_re) begin
      grad_rdata <= grad_mem[grad_raddr];
    end
  end

endmodule

>>> design/fbm_gradient_noise_2d.sv
// Top level: fBm gradient noise sequencer around one shared multiplier.
//
// channel   dir  handshake            payload
// item      in   start & !busy        fbm_item_t (op, table index, loads, coords)
// result    out  result_valid strobe  fbm_result_t (height, min, max)
// config    in   cfg_we               cfg_addr, cfg_data
//
// Load items write their table entry directly; busy stays low.
// A sample keeps busy high while it runs its N octaves, N the clamped octave count:
// every multiply, table read and blend goes through the one multiplier
// and the single read port of each table. The result strobe comes the cycle after.
// Synchronous active-high reset clears control, sets config to its defaults and resets min/max.
// The receiver cannot stall; each result is shown for exactly one cycle.
module fbm_gradient_noise_2d #(
  parameter int TABLE_SIZE  = 256,
  parameter int MAX_OCTAVES = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  fbm_pkg::fbm_item_t         item,
  output logic                       result_valid,
  output fbm_pkg::fbm_result_t       result,
  input  logic                       cfg_we,
  input  fbm_pkg::reg_idx_t          cfg_addr,
  input  logic [fbm_pkg::FREQ_W-1:0] cfg_data
);
  import fbm_pkg::*;

  localparam int TB = $clog2(TABLE_SIZE);
  localparam int PW = 24 + TB;
  localparam int KW = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int SW = 28;

  state_t state, state_next;

  logic [OCT_W-1:0]      octave_count;
  logic [FREQ_W-1:0]     base_frequency;
  logic [COORD_BITS-1:0] cx, cz;
  logic [KW-1:0]         k, klast;
  logic                  fsel;
  logic [1:0]            corner;
  logic [PW-1:0]         px, pz;
  logic [31:0]           t2;
  logic [15:0]           su, sv;
  logic signed [32:0]    dacc;
  logic signed [33:0]    d [4];
  logic signed [34:0]    la, lb;
  logic signed [SW-1:0]  sum;
  logic [HEIGHT_W-1:0]   running_min, running_max;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  logic          perm_re, grad_re;
  logic [TB-1:0] perm_raddr, grad_raddr;
  logic [7:0]    perm_rdata;
  logic [31:0]   grad_rdata;

  logic          accept;
  logic [TB-1:0] x0, y0, xc, yc;
  logic [15:0]   fu, fv, tf;
  logic [37:0]   poly;
  logic signed [35:0] n_val;
  logic signed [36:0] n_bias, term_full;
  logic [5:0]         sh;
  logic signed [SW-1:0] term;
  logic [HEIGHT_W-1:0]  h, min_next, max_next;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  assign x0 = px[PW-1:24];
  assign y0 = pz[PW-1:24];
  assign fu = px[23:8];
  assign fv = pz[23:8];
  assign xc = corner[0] ? x0 + TB'(1) : x0;
  assign yc = corner[1] ? y0 + TB'(1) : y0;
  assign tf = fsel ? fv : fu;

  assign poly = ({6'd0, t2} << 2) + ({6'd0, t2} << 1) + (38'd10 << 32)
              - ((({22'd0, tf} << 4) - {22'd0, tf}) << 16);

  assign n_val     = 36'(la) + mul_p[51:16];
  assign n_bias    = 37'(n_val) + (37'sd1 <<< 30);
  assign sh        = 6'd15 + 6'(k);
  assign term_full = n_bias >>> sh;
  assign term      = SW'(term_full);

  always_comb begin
    if (sum < 0) begin
      h = '0;
    end else if (sum > SW'(HEIGHT_MAX)) begin
      h = HEIGHT_MAX;
    end else begin
      h = HEIGHT_W'(sum);
    end
    min_next = (h < running_min) ? h : running_min;
    max_next = (h > running_max) ? h : running_max;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept && item.op == OP_SAMPLE) state_next = S_SCL_X;
      S_SCL_X:  state_next = S_SCL_Z;
      S_SCL_Z:  state_next = S_SCL_W;
      S_SCL_W:  state_next = S_F_SQ;
      S_F_SQ:   state_next = S_F_CUBE;
      S_F_CUBE: state_next = S_F_POLY;
      S_F_POLY: state_next = S_F_DONE;
      S_F_DONE: state_next = fsel ? S_H_P1 : S_F_SQ;
      S_H_P1:   state_next = S_H_P2;
      S_H_P2:   state_next = S_H_G;
      S_H_G:    state_next = S_D_X;
      S_D_X:    state_next = S_D_Y;
      S_D_Y:    state_next = S_D_S;
      S_D_S:    state_next = (corner == 2'd3) ? S_L_A : S_H_P1;
      S_L_A:    state_next = S_L_B;
      S_L_B:    state_next = S_L_C;
      S_L_C:    state_next = S_L_D;
      S_L_D:    state_next = S_L_E;
      S_L_E:    state_next = (k == klast) ? S_FIN : S_F_SQ;
      S_FIN:    state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // multiplier operands and table reads
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    perm_re    = 1'b0;
    grad_re    = 1'b0;
    perm_raddr = xc;
    grad_raddr = TB'(perm_rdata);
    unique case (state)
      S_SCL_X: begin
        mul_a = MUL_A_W'(base_frequency);
        mul_b = MUL_B_W'(cx);
      end
      S_SCL_Z: begin
        mul_a = MUL_A_W'(base_frequency);
        mul_b = MUL_B_W'(cz);
      end
      S_F_SQ: begin
        mul_a = MUL_A_W'(tf);
        mul_b = MUL_B_W'(tf);
      end
      S_F_CUBE: begin
        mul_a = MUL_A_W'(mul_p[31:0]);
        mul_b = MUL_B_W'(tf);
      end
      S_F_POLY: begin
        mul_a = MUL_A_W'(mul_p[47:16]);
        mul_b = MUL_B_W'(poly[35:16]);
      end
      S_H_P1: begin
        perm_re = 1'b1;
      end
      S_H_P2: begin
        perm_re    = 1'b1;
        perm_raddr = TB'(32'(perm_rdata) + 32'(yc));
      end
      S_H_G: begin
        grad_re = 1'b1;
      end
      S_D_X: begin
        mul_a = MUL_A_W'($signed({corner[0], fu}));
        mul_b = MUL_B_W'($signed(grad_rdata[15:0]));
      end
      S_D_Y: begin
        mul_a = MUL_A_W'($signed({corner[1], fv}));
        mul_b = MUL_B_W'($signed(grad_rdata[31:16]));
      end
      S_L_A: begin
        mul_a = MUL_A_W'(35'(d[1]) - 35'(d[0]));
        mul_b = MUL_B_W'(su);
      end
      S_L_B: begin
        mul_a = MUL_A_W'(35'(d[3]) - 35'(d[2]));
        mul_b = MUL_B_W'(su);
      end
      S_L_D: begin
        mul_a = MUL_A_W'(lb) - MUL_A_W'(la);
        mul_b = MUL_B_W'(sv);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      octave_count   <= OCT_W'(3);
      base_frequency <= FREQ_W'(83886);
      running_min    <= HEIGHT_MAX;
      running_max    <= '0;
      result_valid   <= 1'b0;
      fsel           <= 1'b0;
      corner         <= '0;
      k              <= '0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_OCTAVE_COUNT: octave_count   <= cfg_data[OCT_W-1:0];
          REG_BASE_FREQ:    base_frequency <= cfg_data;
          default: begin
          end
        endcase
      end
      unique case (state)
        S_IDLE: begin
          k      <= '0;
          fsel   <= 1'b0;
          corner <= '0;
        end
        S_F_DONE: begin
          fsel <= !fsel;
          corner <= '0;
        end
        S_D_S: begin
          corner <= corner + 2'd1;
        end
        S_L_E: begin
          k <= k + KW'(1);
        end
        S_FIN: begin
          running_min  <= min_next;
          running_max  <= max_next;
          result_valid <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept && item.op == OP_SAMPLE) begin
      cx  <= item.coord_x;
      cz  <= item.coord_z;
      sum <= '0;
      if (octave_count == '0) begin
        klast <= '0;
      end else if (32'(octave_count) >= MAX_OCTAVES) begin
        klast <= KW'(MAX_OCTAVES - 1);
      end else begin
        klast <= KW'(octave_count - OCT_W'(1));
      end
    end
    unique case (state)
      S_SCL_Z:  px <= PW'(mul_p);
      S_SCL_W:  pz <= PW'(mul_p);
      S_F_CUBE: t2 <= mul_p[31:0];
      S_F_DONE: begin
        if (fsel) begin
          sv <= mul_p[47:32];
        end else begin
          su <= mul_p[47:32];
        end
      end
      S_D_Y:    dacc <= mul_p[32:0];
      S_D_S:    d[corner] <= 34'(dacc) + 34'($signed(mul_p[32:0]));
      S_L_B:    la <= 35'(d[0]) + mul_p[50:16];
      S_L_C:    lb <= 35'(d[2]) + mul_p[50:16];
      S_L_E: begin
        sum <= sum + term;
        px  <= px << 1;
        pz  <= pz << 1;
      end
      S_FIN: begin
        result.height     <= h;
        result.min_height <= min_next;
        result.max_height <= max_next;
      end
      default: begin
      end
    endcase
  end

  fbm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  fbm_tables #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_tables (
    .clk        (clk),
    .perm_we    (accept && item.op == OP_LOAD_PERM),
    .grad_we    (accept && item.op == OP_LOAD_GRAD),
    .waddr      (TB'(item.table_index)),
    .perm_wdata (item.perm_value),
    .grad_wdata ({item.grad_y, item.grad_x}),
    .perm_re    (perm_re),
    .perm_raddr (perm_raddr),
    .grad_re    (grad_re),
    .grad_raddr (grad_raddr),
    .perm_rdata (perm_rdata),
    .grad_rdata (grad_rdata)
  );

  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy) else $error("result strobe while busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid) else $error("result strobe longer than one cycle");

  a_minmax_order: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.min_height <= result.height) &&
                     (result.height <= result.max_height))
    else $error("height outside running min/max");

  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.op == OP_SAMPLE) |=> busy)
    else $error("sample transfer did not start work");

endmodule
